// ----- sv/hed_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the HTML character entity decoder.
// Depends on nothing; every file of the block but hed_ram imports it.
package hed_pkg;

  localparam int unsigned HOLD_DEPTH_DEF = 32;
  localparam int unsigned NUM_NAMES = 6;

  localparam logic [7:0] AMP_CHAR  = 8'h26;
  localparam logic [7:0] SEMI_CHAR = 8'h3B;
  localparam logic [7:0] HASH_CHAR = 8'h23;
  localparam logic [7:0] DIG0_CHAR = 8'h30;
  localparam logic [7:0] DIG9_CHAR = 8'h39;
  localparam logic [5:0] ALL_NAMES = 6'h3F;

  // Names in priority order: nbsp, quot, amp, apos, lt, gt.
  localparam logic [7:0] NAME_TEXT [NUM_NAMES][4] = '{
    '{8'h6E, 8'h62, 8'h73, 8'h70},
    '{8'h71, 8'h75, 8'h6F, 8'h74},
    '{8'h61, 8'h6D, 8'h70, 8'h00},
    '{8'h61, 8'h70, 8'h6F, 8'h73},
    '{8'h6C, 8'h74, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h00, 8'h00}
  };
  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd4, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2};
  localparam logic [7:0] NAME_CHAR [NUM_NAMES] = '{
    8'h20, 8'h22, 8'h26, 8'h27, 8'h3C, 8'h3E
  };

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NAME   = 4'b0010,
    MODE_DIGITS = 4'b0100,
    MODE_TAIL   = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_REL  = 3'b010,
    SEQ_TAIL = 3'b100
  } seq_e;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_BYTE = 2'd1,
    TAIL_NUM  = 2'd2
  } tail_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] value;
    logic        digit_seen;
    logic [5:0]  cand;
    logic [2:0]  pos;
  } parse_t;

  localparam parse_t IDLE_PARSE = '{
    mode: MODE_IDLE, value: 32'd0, digit_seen: 1'b0, cand: ALL_NAMES, pos: 3'd0
  };

  // What one accepted word causes: release of the held bytes, then a tail; or holding of the byte.
  typedef struct packed {
    logic        rel;
    tail_e       tail;
    logic [31:0] tail_val;
    logic        hold;
  } step_act_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       text_done;
  } out_word_t;

endpackage

// ----- sv/html_entity_decoder.sv -----
`timescale 1ns / 1ps
// A plain byte or a decoded named entity is in the output register in the cycle after its
// word is accepted; plain text runs at one word per cycle unless the output stalls.
// Bytes of an open entity are taken one per cycle, output permitting, and yield no word.
// A release reads the held-byte RAM once per byte; a numeric entity yields up to 4 bytes;
// no word is taken meanwhile. Reset is asynchronous, active low, and clears the parser and
// output valid; the RAM is not cleared. Depends on hed_pkg, hed_step and hed_ram.
module html_entity_decoder import hed_pkg::*; #(
  parameter int unsigned HoldDepth = HOLD_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned CntW = $clog2(HoldDepth + 1);
  localparam int unsigned IdxW = $clog2(HoldDepth);

  seq_e            seq_q, seq_d;
  parse_t          parse_q, parse_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  step_act_t       act;

  logic [CntW-1:0] rel_n_q, rel_n_d;
  logic [IdxW-1:0] idx_q, idx_d;
  tail_e           tail_kind_q, tail_kind_d;
  logic [31:0]     tail_val_q, tail_val_d;
  logic            eot_q, eot_d;

  logic            out_valid_q;
  out_word_t       out_word_q, out_d;
  logic            out_load;
  logic            out_free;
  logic            accept;

  logic [IdxW-1:0] rd_addr;
  logic [7:0]      rd_data;
  logic [7:0]      rel_byte;
  logic            rel_last;
  logic            tail_last;
  logic            no_tail;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (seq_q == SEQ_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  hed_step #(.HoldDepth(HoldDepth)) u_step (
    .st_i   (parse_q),
    .cnt_i  (cnt_q),
    .byte_i (in_word_i.in_byte),
    .eot_i  (in_word_i.end_of_text),
    .st_o   (parse_d),
    .cnt_o  (cnt_d),
    .act_o  (act)
  );

  hed_ram #(.Width(8), .Depth(HoldDepth)) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (accept && act.hold),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (in_word_i.in_byte),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rel_byte  = (idx_q == '0) ? AMP_CHAR : rd_data;
  assign rel_last  = ((CntW'(idx_q) + CntW'(1)) == rel_n_q);
  assign no_tail   = (tail_kind_q == TAIL_NONE);
  assign tail_last = (tail_kind_q == TAIL_BYTE) || (tail_val_q[15:8] == 8'd0);

  always_comb begin
    seq_d       = seq_q;
    rel_n_d     = rel_n_q;
    idx_d       = idx_q;
    tail_kind_d = tail_kind_q;
    tail_val_d  = tail_val_q;
    eot_d       = eot_q;
    out_load    = 1'b0;
    out_d       = out_word_q;
    // The read address runs one step ahead so that the RAM output matches idx_q.
    rd_addr     = idx_q;

    case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          rel_n_d     = cnt_q;
          idx_d       = '0;
          tail_kind_d = act.tail;
          tail_val_d  = act.tail_val;
          eot_d       = in_word_i.end_of_text;
          if (act.rel) begin
            seq_d = SEQ_REL;
          end else if (act.tail == TAIL_NUM) begin
            seq_d = SEQ_TAIL;
          end else if (act.tail == TAIL_BYTE) begin
            out_load = 1'b1;
            out_d    = '{out_byte: act.tail_val[7:0], last_in_run: 1'b1,
                         text_done: in_word_i.end_of_text};
          end
        end
      end
      SEQ_REL: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{out_byte: rel_byte, last_in_run: rel_last && no_tail,
                       text_done: rel_last && no_tail && eot_q};
          if (rel_last) begin
            seq_d = no_tail ? SEQ_IDLE : SEQ_TAIL;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            rd_addr = idx_q + IdxW'(1);
          end
        end
      end
      SEQ_TAIL: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{out_byte: tail_val_q[7:0], last_in_run: tail_last,
                       text_done: tail_last && eot_q};
          if (tail_last) begin
            seq_d = SEQ_IDLE;
          end else begin
            tail_val_d = tail_val_q >> 8;
          end
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      parse_q     <= IDLE_PARSE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (accept) begin
        parse_q <= parse_d;
        cnt_q   <= cnt_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rel_n_q     <= rel_n_d;
    idx_q       <= idx_d;
    tail_kind_q <= tail_kind_d;
    tail_val_q  <= tail_val_d;
    eot_q       <= eot_d;
    if (out_load) begin
      out_word_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- sv/hed_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hed_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/hed_step.sv -----
`timescale 1ns / 1ps
// Parser next-state logic: decides for one input word what is held, released
// and emitted. Depends on hed_pkg.
module hed_step import hed_pkg::*; #(
  parameter int unsigned HoldDepth = HOLD_DEPTH_DEF,
  localparam int unsigned CntW = $clog2(HoldDepth + 1)
) (
  input  parse_t          st_i,
  input  logic [CntW-1:0] cnt_i,
  input  logic [7:0]      byte_i,
  input  logic            eot_i,
  output parse_t          st_o,
  output logic [CntW-1:0] cnt_o,
  output step_act_t       act_o
);

  logic [5:0]  term;
  logic [5:0]  keep;
  logic [7:0]  term_char;
  logic [31:0] val_next;
  logic        full;
  logic        is_digit;

  always_comb begin
    term_char = NAME_CHAR[0];
    for (int i = 0; i < NUM_NAMES; i++) begin
      term[i] = st_i.cand[i] && (NAME_LEN[i] == st_i.pos) && (byte_i == SEMI_CHAR);
      keep[i] = st_i.cand[i] && (NAME_LEN[i] != st_i.pos) && (st_i.pos < 3'd4) &&
                (NAME_TEXT[i][st_i.pos[1:0]] == byte_i);
    end
    // The earliest terminated name wins.
    for (int i = NUM_NAMES - 1; i >= 0; i--) begin
      if (term[i]) begin
        term_char = NAME_CHAR[i];
      end
    end
  end

  assign full     = (cnt_i == CntW'(HoldDepth));
  assign is_digit = byte_i inside {[DIG0_CHAR:DIG9_CHAR]};
  assign val_next = (st_i.value << 3) + (st_i.value << 1) + {24'd0, byte_i - DIG0_CHAR};

  always_comb begin
    logic from_idle;
    logic opened;
    from_idle = 1'b0;
    opened    = 1'b0;
    st_o      = st_i;
    cnt_o     = cnt_i;
    act_o     = '{rel: 1'b0, tail: TAIL_NONE, tail_val: 32'd0, hold: 1'b0};

    case (st_i.mode)
      MODE_IDLE: begin
        from_idle = 1'b1;
      end
      MODE_NAME: begin
        if (st_i.pos == 3'd0 && byte_i == HASH_CHAR) begin
          act_o.hold      = 1'b1;
          cnt_o           = cnt_i + CntW'(1);
          st_o.mode       = MODE_DIGITS;
          st_o.value      = 32'd0;
          st_o.digit_seen = 1'b0;
        end else if (term != 6'd0) begin
          act_o.tail     = TAIL_BYTE;
          act_o.tail_val = {24'd0, term_char};
          st_o           = IDLE_PARSE;
          cnt_o          = '0;
        end else if (keep != 6'd0) begin
          act_o.hold = 1'b1;
          cnt_o      = cnt_i + CntW'(1);
          st_o.cand  = keep;
          st_o.pos   = st_i.pos + 3'd1;
        end else begin
          act_o.rel = 1'b1;
          from_idle = 1'b1;
        end
      end
      MODE_DIGITS, MODE_TAIL: begin
        if (st_i.mode == MODE_DIGITS && is_digit) begin
          if (full) begin
            act_o.rel = 1'b1;
            from_idle = 1'b1;
          end else begin
            act_o.hold      = 1'b1;
            cnt_o           = cnt_i + CntW'(1);
            st_o.value      = val_next;
            st_o.digit_seen = 1'b1;
          end
        end else if (st_i.mode == MODE_TAIL ||
                     (st_i.digit_seen && st_i.value != 32'd0)) begin
          if (byte_i == SEMI_CHAR) begin
            act_o.tail     = TAIL_NUM;
            act_o.tail_val = st_i.value;
            st_o           = IDLE_PARSE;
            cnt_o          = '0;
          end else if (full) begin
            act_o.rel = 1'b1;
            from_idle = 1'b1;
          end else begin
            act_o.hold = 1'b1;
            cnt_o      = cnt_i + CntW'(1);
            st_o.mode  = MODE_TAIL;
          end
        end else begin
          act_o.rel = 1'b1;
          from_idle = 1'b1;
        end
      end
      default: begin
        from_idle = 1'b1;
      end
    endcase

    if (from_idle) begin
      st_o = IDLE_PARSE;
      if (byte_i == AMP_CHAR) begin
        // The ampersand is never written: held entry zero is always one.
        st_o.mode = MODE_NAME;
        cnt_o     = CntW'(1);
        opened    = 1'b1;
      end else begin
        cnt_o          = '0;
        act_o.tail     = TAIL_BYTE;
        act_o.tail_val = {24'd0, byte_i};
      end
    end

    // At the end of the text anything still held goes out raw, this word last, unless it closes the entity.
    if (eot_i) begin
      if (act_o.hold) begin
        act_o.hold     = 1'b0;
        act_o.rel      = 1'b1;
        act_o.tail     = TAIL_BYTE;
        act_o.tail_val = {24'd0, byte_i};
      end else if (opened) begin
        act_o.tail     = TAIL_BYTE;
        act_o.tail_val = {24'd0, byte_i};
      end
      st_o  = IDLE_PARSE;
      cnt_o = '0;
    end
  end

endmodule

// ----- sv/hed_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the entity decoder and the bind that attaches them.
// Depends on hed_pkg and html_entity_decoder.
module hed_props import hed_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // A new word is taken only when the output register can take its result.
  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input ready while the output word is stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word dropped or changed");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.text_done) |-> out_word_o.last_in_run)
    else $error("end of text flagged on a word that does not close its run");

  // The final word of a string always yields a result that is still owed.
  a_eot_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_word_i.end_of_text) |=> (out_valid_o || !in_ready_o))
    else $error("end of text accepted without a pending result");

endmodule

bind html_entity_decoder hed_props u_hed_props (.*);
